// ===== rtl/core/cme_pkg.sv =====
package cme_pkg;

    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int LOAD_ADDR_W = 7;
    localparam int CTR_W = 7;
    localparam int UPC_W = 5;
    localparam int DIGIT_BASE = 10;

    // ASCII codes used by the instruction decoder.
    localparam logic [BYTE_W-1:0] CH_L = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_S = 8'h53;
    localparam logic [BYTE_W-1:0] CH_C = 8'h43;
    localparam logic [BYTE_W-1:0] CH_B = 8'h42;
    localparam logic [BYTE_W-1:0] CH_G = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P = 8'h50;
    localparam logic [BYTE_W-1:0] CH_H = 8'h48;
    localparam logic [BYTE_W-1:0] CH_R = 8'h52;
    localparam logic [BYTE_W-1:0] CH_D = 8'h44;
    localparam logic [BYTE_W-1:0] CH_T = 8'h54;
    localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9 = 8'h39;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EXEC  = 2'd1,
        OP_CARD  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_DONE = 3'd0,
        K_CARD = 3'd1,
        K_BYTE = 3'd2,
        K_EOL  = 3'd3,
        K_HALT = 3'd4,
        K_ERR  = 3'd5
    } kind_t;

    typedef struct packed {
        op_t                    op;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic [WORD_W-1:0]      word_in;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  out_byte;
        logic               last;
        logic [CTR_W-1:0]   next_counter;
        logic               compare_flag;
    } rsp_t;

    // Decoded instruction class, used for the microcode dispatch.
    typedef enum logic [3:0] {
        IC_NOP,
        IC_HALT,
        IC_BAD,
        IC_LR,
        IC_SR,
        IC_CR,
        IC_BT,
        IC_GD,
        IC_PD
    } insn_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_LOAD_WR,
        ACT_CLEAR,
        ACT_CARD_ST,
        ACT_SET_HALT,
        ACT_PC_ADV,
        ACT_LATCH_IR,
        ACT_LOAD_R,
        ACT_SR_WR,
        ACT_CMP,
        ACT_BRANCH,
        ACT_GD,
        ACT_PR_INIT,
        ACT_PR_LATCH,
        ACT_PR_SHIFT
    } act_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PC,
        RD_OPND,
        RD_PRINT
    } rd_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_DONE,
        EM_CARD,
        EM_BYTE,
        EM_EOL,
        EM_HALT,
        EM_ERR
    } emit_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF,
        J_OP,
        J_INSN
    } jump_t;

    typedef enum logic [2:0] {
        C_NOT_AWAIT,
        C_CARD_LAST,
        C_HALTED,
        C_AWAIT,
        C_BYTE_MORE,
        C_WORD_MORE
    } cond_t;

    typedef logic [UPC_W-1:0] upc_t;

    // One microcode control word.
    typedef struct packed {
        act_t  act;
        rd_t   rd;
        emit_t emit;
        jump_t jump;
        cond_t cond;
        upc_t  target;
        logic  wait_in;
        logic  pr_next;
    } ctl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic  in_valid;
        logic  emit_blocked;
        op_t   op;
        insn_t insn;
        logic  halted;
        logic  await;
        logic  card_last;
        logic  byte_more;
        logic  word_more;
    } stat_t;

endpackage

// ===== rtl/core/cme_mem.sv =====
// Word store with one write and one registered read port. A flag per word
// makes entries read as zero until written since the last clear.
module cme_mem #(
    parameter int DEPTH = 100,
    parameter int AW = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clr,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [cme_pkg::WORD_W-1:0]     wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [cme_pkg::WORD_W-1:0]     rd_data
);

    logic [cme_pkg::WORD_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [cme_pkg::WORD_W-1:0] rdata_reg;
    logic                       rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/cme_sequencer.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module cme_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  cme_pkg::stat_t  stat,
    output cme_pkg::ctl_t   ctl,
    output logic            go
);

    localparam cme_pkg::upc_t U_IDLE     = 5'd0;
    localparam cme_pkg::upc_t U_LOAD     = 5'd1;
    localparam cme_pkg::upc_t U_CLEAR    = 5'd2;
    localparam cme_pkg::upc_t U_CARD_CHK = 5'd3;
    localparam cme_pkg::upc_t U_CARD_ST  = 5'd4;
    localparam cme_pkg::upc_t U_ECARD    = 5'd5;
    localparam cme_pkg::upc_t U_EDONE    = 5'd6;
    localparam cme_pkg::upc_t U_EHALT    = 5'd7;
    localparam cme_pkg::upc_t U_EERR     = 5'd8;
    localparam cme_pkg::upc_t U_EXEC     = 5'd9;
    localparam cme_pkg::upc_t U_EXEC2    = 5'd10;
    localparam cme_pkg::upc_t U_FETCH    = 5'd11;
    localparam cme_pkg::upc_t U_LATCH    = 5'd12;
    localparam cme_pkg::upc_t U_DISP     = 5'd13;
    localparam cme_pkg::upc_t U_LR       = 5'd14;
    localparam cme_pkg::upc_t U_LR2      = 5'd15;
    localparam cme_pkg::upc_t U_SR       = 5'd16;
    localparam cme_pkg::upc_t U_CR       = 5'd17;
    localparam cme_pkg::upc_t U_CR2      = 5'd18;
    localparam cme_pkg::upc_t U_BT       = 5'd19;
    localparam cme_pkg::upc_t U_GD       = 5'd20;
    localparam cme_pkg::upc_t U_PD       = 5'd21;
    localparam cme_pkg::upc_t U_PR_RD    = 5'd22;
    localparam cme_pkg::upc_t U_PR_LATCH = 5'd23;
    localparam cme_pkg::upc_t U_PR_BYTE  = 5'd24;
    localparam cme_pkg::upc_t U_PR_NEXT  = 5'd25;
    localparam cme_pkg::upc_t U_PR_EOL   = 5'd26;

    function automatic cme_pkg::ctl_t mk(
        input cme_pkg::act_t  a,
        input cme_pkg::rd_t   r,
        input cme_pkg::emit_t e,
        input cme_pkg::jump_t j,
        input cme_pkg::cond_t c,
        input cme_pkg::upc_t  t
    );
        cme_pkg::ctl_t w;
        w.act     = a;
        w.rd      = r;
        w.emit    = e;
        w.jump    = j;
        w.cond    = c;
        w.target  = t;
        w.wait_in = 1'b0;
        w.pr_next = 1'b0;
        return w;
    endfunction

    // The control store.
    function automatic cme_pkg::ctl_t ucode(input cme_pkg::upc_t s);
        cme_pkg::ctl_t w;
        unique case (s)
            U_IDLE:
            begin
                w = mk(cme_pkg::ACT_ACCEPT, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                       cme_pkg::J_OP, cme_pkg::C_HALTED, U_IDLE);
                w.wait_in = 1'b1;
            end
            U_LOAD:     w = mk(cme_pkg::ACT_LOAD_WR, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_CLEAR:    w = mk(cme_pkg::ACT_CLEAR, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_CARD_CHK: w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_IF, cme_pkg::C_NOT_AWAIT, U_EDONE);
            U_CARD_ST:  w = mk(cme_pkg::ACT_CARD_ST, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_IF, cme_pkg::C_CARD_LAST, U_EDONE);
            U_ECARD:    w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_CARD,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
            U_EDONE:    w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_DONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
            U_EHALT:    w = mk(cme_pkg::ACT_SET_HALT, cme_pkg::RD_NONE, cme_pkg::EM_HALT,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
            U_EERR:     w = mk(cme_pkg::ACT_SET_HALT, cme_pkg::RD_NONE, cme_pkg::EM_ERR,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
            U_EXEC:     w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_IF, cme_pkg::C_HALTED, U_EHALT);
            U_EXEC2:    w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_IF, cme_pkg::C_AWAIT, U_ECARD);
            U_FETCH:    w = mk(cme_pkg::ACT_PC_ADV, cme_pkg::RD_PC, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_LATCH:    w = mk(cme_pkg::ACT_LATCH_IR, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_DISP:     w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_INSN, cme_pkg::C_HALTED, U_IDLE);
            U_LR:       w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_OPND, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_LR2:      w = mk(cme_pkg::ACT_LOAD_R, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_SR:       w = mk(cme_pkg::ACT_SR_WR, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_CR:       w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_OPND, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_CR2:      w = mk(cme_pkg::ACT_CMP, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_BT:       w = mk(cme_pkg::ACT_BRANCH, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_EDONE);
            U_GD:       w = mk(cme_pkg::ACT_GD, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_ECARD);
            U_PD:       w = mk(cme_pkg::ACT_PR_INIT, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_PR_RD:    w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_PRINT, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_PR_LATCH: w = mk(cme_pkg::ACT_PR_LATCH, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_NEXT, cme_pkg::C_HALTED, U_IDLE);
            U_PR_BYTE:  w = mk(cme_pkg::ACT_PR_SHIFT, cme_pkg::RD_NONE, cme_pkg::EM_BYTE,
                               cme_pkg::J_IF, cme_pkg::C_BYTE_MORE, U_PR_BYTE);
            U_PR_NEXT:
            begin
                w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                       cme_pkg::J_IF, cme_pkg::C_WORD_MORE, U_PR_RD);
                w.pr_next = 1'b1;
            end
            U_PR_EOL:   w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_EOL,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
            default:    w = mk(cme_pkg::ACT_NONE, cme_pkg::RD_NONE, cme_pkg::EM_NONE,
                               cme_pkg::J_GOTO, cme_pkg::C_HALTED, U_IDLE);
        endcase
        return w;
    endfunction

    cme_pkg::upc_t step_reg;
    cme_pkg::upc_t step_next;
    logic          cond_hit;

    assign ctl = ucode(step_reg);

    always_comb
    begin
        go = !(ctl.wait_in && !stat.in_valid) && !stat.emit_blocked;

        unique case (ctl.cond)
            cme_pkg::C_NOT_AWAIT: cond_hit = !stat.await;
            cme_pkg::C_CARD_LAST: cond_hit = stat.card_last;
            cme_pkg::C_HALTED:    cond_hit = stat.halted;
            cme_pkg::C_AWAIT:     cond_hit = stat.await;
            cme_pkg::C_BYTE_MORE: cond_hit = stat.byte_more;
            cme_pkg::C_WORD_MORE: cond_hit = stat.word_more;
            default:              cond_hit = 1'b0;
        endcase

        unique case (ctl.jump)
            cme_pkg::J_NEXT: step_next = step_reg + 5'd1;
            cme_pkg::J_GOTO: step_next = ctl.target;
            cme_pkg::J_IF:   step_next = cond_hit ? ctl.target : step_reg + 5'd1;
            cme_pkg::J_OP:
            begin
                unique case (stat.op)
                    cme_pkg::OP_LOAD:  step_next = U_LOAD;
                    cme_pkg::OP_EXEC:  step_next = U_EXEC;
                    cme_pkg::OP_CARD:  step_next = U_CARD_CHK;
                    cme_pkg::OP_CLEAR: step_next = U_CLEAR;
                    default:           step_next = U_IDLE;
                endcase
            end
            cme_pkg::J_INSN:
            begin
                unique case (stat.insn)
                    cme_pkg::IC_NOP:  step_next = U_EDONE;
                    cme_pkg::IC_HALT: step_next = U_EHALT;
                    cme_pkg::IC_BAD:  step_next = U_EERR;
                    cme_pkg::IC_LR:   step_next = U_LR;
                    cme_pkg::IC_SR:   step_next = U_SR;
                    cme_pkg::IC_CR:   step_next = U_CR;
                    cme_pkg::IC_BT:   step_next = U_BT;
                    cme_pkg::IC_GD:   step_next = U_GD;
                    cme_pkg::IC_PD:   step_next = U_PD;
                    default:          step_next = U_EDONE;
                endcase
            end
            default: step_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= U_IDLE;
        end
        else if (go)
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/core/card_machine_instruction_executor.sv =====
// Card machine instruction executor: a small stored-program machine with a
// word store, one register R, an equality flag and an instruction counter.
// The command channel (cmd_valid, cmd_stall, cmd) takes one item per transfer:
// load a program word, execute one instruction, hand in a card word, or clear
// the whole machine for a new job. Each item produces one or more result
// transfers on the response channel (rsp_valid, rsp_stall, rsp); the final
// result of an item carries rsp.last.
// A microcoded sequencer runs the item. A step is refused while halted or
// while a card is awaited. An executed instruction fetches its word and any
// operand through the word store; a print reads its block word by word, with
// the same steps for every word whatever bytes it holds. The next command is
// taken in the cycle after the last result enters the output register.
// The response is held in an output register; while rsp_stall is high the
// sequencer waits at its next result step and the held transfer stays put.
// Reset clears the register, flag, counter, mode and card state and marks
// every store word as zero; no clearing pass is needed.
module card_machine_instruction_executor #(
    parameter int MEM_WORDS = 100,
    parameter int WORDS_PER_CARD = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  cme_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cme_pkg::rsp_t   rsp
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int CNT_W = (WORDS_PER_CARD > 1) ? $clog2(WORDS_PER_CARD) : 1;

    typedef enum logic [1:0] {
        MODE_RUN,
        MODE_CARD,
        MODE_HALT
    } mode_t;

    cme_pkg::ctl_t  ctl;
    cme_pkg::stat_t stat;
    logic           go;

    // Architectural state.
    logic [AW-1:0]              pc_reg;
    logic [cme_pkg::WORD_W-1:0] r_reg;
    logic                       flag_reg;
    mode_t                      mode_reg;
    logic [AW-1:0]              card_base_reg;
    logic [CNT_W-1:0]           card_cnt_reg;

    // Working registers of the datapath.
    logic [cme_pkg::LOAD_ADDR_W-1:0] load_lat_reg;
    logic [cme_pkg::WORD_W-1:0]      word_lat_reg;
    logic [cme_pkg::WORD_W-1:0]      ir_reg;
    logic [cme_pkg::WORD_W-1:0]      sh_reg;
    logic [1:0]                      bidx_reg;
    logic [AW-1:0]                   paddr_reg;
    logic [CNT_W-1:0]                pcnt_reg;

    logic          rsp_valid_reg;
    cme_pkg::rsp_t rsp_reg;

    // Word store connections.
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [cme_pkg::WORD_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [cme_pkg::WORD_W-1:0] mem_rd_data;
    logic                       mem_clr;

    // Instruction decode.
    logic [cme_pkg::BYTE_W-1:0] b0, b1, b2, b3;
    logic                       d2_ok, d3_ok;
    logic [3:0]                 d2, d3;
    logic [6:0]                 addr_dec;
    logic                       addr_over, block_over;
    logic [AW-1:0]              opnd;
    cme_pkg::insn_t             insn;
    cme_pkg::insn_t             insn_op;

    logic                       load_ok;
    logic                       emit_need;
    logic                       emit_fire;
    logic                       room;
    logic [cme_pkg::BYTE_W-1:0] top_byte;
    cme_pkg::kind_t             emit_kind;

    assign b0 = ir_reg[31:24];
    assign b1 = ir_reg[23:16];
    assign b2 = ir_reg[15:8];
    assign b3 = ir_reg[7:0];

    assign d2_ok = (b2 >= cme_pkg::CH_0) && (b2 <= cme_pkg::CH_9);
    assign d3_ok = (b3 >= cme_pkg::CH_0) && (b3 <= cme_pkg::CH_9);
    assign d2 = b2[3:0];
    assign d3 = b3[3:0];
    assign addr_dec = 7'(d2) * 7'(cme_pkg::DIGIT_BASE) + 7'(d3);
    assign addr_over = {1'b0, addr_dec} >= 8'(MEM_WORDS);
    assign block_over = ({1'b0, addr_dec} + 8'(WORDS_PER_CARD)) > 8'(MEM_WORDS);
    assign opnd = addr_dec[AW-1:0];

    always_comb
    begin
        priority if (b0 == cme_pkg::CH_L && b1 == cme_pkg::CH_R) insn_op = cme_pkg::IC_LR;
        else if (b0 == cme_pkg::CH_S && b1 == cme_pkg::CH_R)     insn_op = cme_pkg::IC_SR;
        else if (b0 == cme_pkg::CH_C && b1 == cme_pkg::CH_R)     insn_op = cme_pkg::IC_CR;
        else if (b0 == cme_pkg::CH_B && b1 == cme_pkg::CH_T)     insn_op = cme_pkg::IC_BT;
        else if (b0 == cme_pkg::CH_G && b1 == cme_pkg::CH_D)     insn_op = cme_pkg::IC_GD;
        else if (b0 == cme_pkg::CH_P && b1 == cme_pkg::CH_D)     insn_op = cme_pkg::IC_PD;
        else                                                     insn_op = cme_pkg::IC_NOP;

        // Halt needs only its first character; an unknown opcode is a no-op
        // before any address check.
        priority if (b0 == cme_pkg::CH_H)
            insn = cme_pkg::IC_HALT;
        else if (insn_op == cme_pkg::IC_NOP)
            insn = cme_pkg::IC_NOP;
        else if (!d2_ok || !d3_ok || addr_over)
            insn = cme_pkg::IC_BAD;
        else if ((insn_op == cme_pkg::IC_GD || insn_op == cme_pkg::IC_PD) && block_over)
            insn = cme_pkg::IC_BAD;
        else
            insn = insn_op;
    end

    // Status for the sequencer.
    assign top_byte  = sh_reg[31:24];
    assign emit_need = (ctl.emit != cme_pkg::EM_NONE) &&
                       ((ctl.emit != cme_pkg::EM_BYTE) || (top_byte != '0));
    assign room      = !rsp_valid_reg || !rsp_stall;
    assign emit_fire = go && emit_need;

    always_comb
    begin
        stat.in_valid     = cmd_valid;
        stat.emit_blocked = emit_need && !room;
        stat.op           = cmd.op;
        stat.insn         = insn;
        stat.halted       = (mode_reg == MODE_HALT);
        stat.await        = (mode_reg == MODE_CARD);
        stat.card_last    = (card_cnt_reg == CNT_W'(WORDS_PER_CARD - 1));
        stat.byte_more    = (bidx_reg != 2'd3);
        stat.word_more    = (pcnt_reg != CNT_W'(WORDS_PER_CARD - 1));
    end

    cme_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl),
        .go    (go)
    );

    // Store port steering. Out-of-range load addresses are dropped.
    assign load_ok = load_lat_reg < 7'(MEM_WORDS);
    assign mem_clr = go && (ctl.act == cme_pkg::ACT_CLEAR);

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = opnd;
        mem_wr_data = r_reg;
        unique case (ctl.act)
            cme_pkg::ACT_LOAD_WR:
            begin
                mem_wr_en   = go && load_ok;
                mem_wr_addr = load_lat_reg[AW-1:0];
                mem_wr_data = word_lat_reg;
            end
            cme_pkg::ACT_CARD_ST:
            begin
                mem_wr_en   = go;
                mem_wr_addr = card_base_reg + AW'(card_cnt_reg);
                mem_wr_data = word_lat_reg;
            end
            cme_pkg::ACT_SR_WR:
            begin
                mem_wr_en   = go;
                mem_wr_addr = opnd;
                mem_wr_data = r_reg;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase

        mem_rd_en = go && (ctl.rd != cme_pkg::RD_NONE);
        unique case (ctl.rd)
            cme_pkg::RD_PC:    mem_rd_addr = pc_reg;
            cme_pkg::RD_OPND:  mem_rd_addr = opnd;
            cme_pkg::RD_PRINT: mem_rd_addr = paddr_reg;
            default:           mem_rd_addr = pc_reg;
        endcase
    end

    cme_mem #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        unique case (ctl.emit)
            cme_pkg::EM_DONE: emit_kind = cme_pkg::K_DONE;
            cme_pkg::EM_CARD: emit_kind = cme_pkg::K_CARD;
            cme_pkg::EM_BYTE: emit_kind = cme_pkg::K_BYTE;
            cme_pkg::EM_EOL:  emit_kind = cme_pkg::K_EOL;
            cme_pkg::EM_HALT: emit_kind = cme_pkg::K_HALT;
            cme_pkg::EM_ERR:  emit_kind = cme_pkg::K_ERR;
            default:          emit_kind = cme_pkg::K_DONE;
        endcase
    end

    // Architectural state and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            r_reg         <= '0;
            flag_reg      <= 1'b0;
            mode_reg      <= MODE_RUN;
            card_base_reg <= '0;
            card_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                unique case (ctl.act)
                    cme_pkg::ACT_CLEAR:
                    begin
                        pc_reg        <= '0;
                        r_reg         <= '0;
                        flag_reg      <= 1'b0;
                        mode_reg      <= MODE_RUN;
                        card_base_reg <= '0;
                        card_cnt_reg  <= '0;
                    end
                    cme_pkg::ACT_CARD_ST:
                    begin
                        if (stat.card_last)
                        begin
                            card_cnt_reg <= '0;
                            mode_reg     <= MODE_RUN;
                        end
                        else
                        begin
                            card_cnt_reg <= card_cnt_reg + 1'b1;
                        end
                    end
                    cme_pkg::ACT_SET_HALT:
                    begin
                        mode_reg <= MODE_HALT;
                    end
                    cme_pkg::ACT_PC_ADV:
                    begin
                        pc_reg <= (pc_reg == AW'(MEM_WORDS - 1)) ? '0 : pc_reg + 1'b1;
                    end
                    cme_pkg::ACT_LOAD_R:
                    begin
                        r_reg <= mem_rd_data;
                    end
                    cme_pkg::ACT_CMP:
                    begin
                        flag_reg <= (r_reg == mem_rd_data);
                    end
                    cme_pkg::ACT_BRANCH:
                    begin
                        if (flag_reg)
                        begin
                            pc_reg <= opnd;
                        end
                    end
                    cme_pkg::ACT_GD:
                    begin
                        mode_reg      <= MODE_CARD;
                        card_base_reg <= opnd;
                        card_cnt_reg  <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (emit_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and the response payload.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            unique case (ctl.act)
                cme_pkg::ACT_ACCEPT:
                begin
                    load_lat_reg <= cmd.load_addr;
                    word_lat_reg <= cmd.word_in;
                end
                cme_pkg::ACT_LATCH_IR:
                begin
                    ir_reg <= mem_rd_data;
                end
                cme_pkg::ACT_PR_INIT:
                begin
                    paddr_reg <= opnd;
                    pcnt_reg  <= '0;
                end
                cme_pkg::ACT_PR_LATCH:
                begin
                    sh_reg   <= mem_rd_data;
                    bidx_reg <= '0;
                end
                cme_pkg::ACT_PR_SHIFT:
                begin
                    sh_reg   <= {sh_reg[23:0], 8'h00};
                    bidx_reg <= bidx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            // Step to the next print word while words remain.
            if (ctl.pr_next && stat.word_more)
            begin
                paddr_reg <= paddr_reg + 1'b1;
                pcnt_reg  <= pcnt_reg + 1'b1;
            end
        end

        if (emit_fire)
        begin
            rsp_reg.kind         <= emit_kind;
            rsp_reg.out_byte     <= (ctl.emit == cme_pkg::EM_BYTE) ? top_byte : '0;
            rsp_reg.last         <= (ctl.emit != cme_pkg::EM_BYTE);
            rsp_reg.next_counter <= cme_pkg::CTR_W'(pc_reg);
            rsp_reg.compare_flag <= flag_reg;
        end
    end

    assign cmd_stall = !ctl.wait_in;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/card_machine_instruction_executor_tb.sv =====
package cme_tb_pkg;

    import cme_pkg::*;

    localparam int STORE_WORDS = 100;
    localparam int CARD_WORDS = 10;
    localparam int MAX_REPORTS = 25;

    // Tracks the machine state as it should be after each accepted command and
    // holds the results that the block still owes.
    class card_machine_checker;

        typedef enum {RUNNING, AWAITING, STOPPED} mode_t;
        typedef enum {I_NONE, I_LR, I_SR, I_CR, I_BT, I_GD, I_PD} insn_code_t;

        logic [WORD_W-1:0] store [STORE_WORDS];
        logic [WORD_W-1:0] reg_r;
        int unsigned       ctr;
        logic              flag;
        mode_t             mode;
        int unsigned       card_base;
        int unsigned       card_count;

        rsp_t              pending_results[$];
        kind_t             step_kind[$];
        logic [BYTE_W-1:0] step_byte[$];

        int errors;
        int checked;
        int kinds_seen[6];
        int ops_seen[4];

        function new();
            clear_machine();
            errors = 0;
            checked = 0;
            foreach (kinds_seen[i]) kinds_seen[i] = 0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
        endfunction

        function void clear_machine();
            foreach (store[i]) store[i] = '0;
            reg_r = '0;
            ctr = 0;
            flag = 1'b0;
            mode = RUNNING;
            card_base = 0;
            card_count = 0;
        endfunction

        function void queue_result(kind_t k, logic [BYTE_W-1:0] b);
            step_kind.push_back(k);
            step_byte.push_back(b);
        endfunction

        function bit is_digit(logic [BYTE_W-1:0] b);
            return b >= CH_0 && b <= CH_9;
        endfunction

        function void run_instruction();
            int unsigned pc;
            int unsigned addr;
            int i;
            int s;
            logic [WORD_W-1:0] ir;
            logic [BYTE_W-1:0] b0, b1, b2, b3;
            insn_code_t code;
            pc = (ctr >= STORE_WORDS) ? 0 : ctr;
            ir = store[pc];
            ctr = (pc + 1 >= STORE_WORDS) ? 0 : pc + 1;
            {b0, b1, b2, b3} = ir;
            if (b0 == CH_H) begin
                mode = STOPPED;
                queue_result(K_HALT, '0);
                return;
            end
            code = I_NONE;
            if (b0 == CH_L && b1 == CH_R) code = I_LR;
            else if (b0 == CH_S && b1 == CH_R) code = I_SR;
            else if (b0 == CH_C && b1 == CH_R) code = I_CR;
            else if (b0 == CH_B && b1 == CH_T) code = I_BT;
            else if (b0 == CH_G && b1 == CH_D) code = I_GD;
            else if (b0 == CH_P && b1 == CH_D) code = I_PD;
            if (code == I_NONE) begin
                queue_result(K_DONE, '0);
                return;
            end
            if (!is_digit(b2) || !is_digit(b3)) begin
                mode = STOPPED;
                queue_result(K_ERR, '0);
                return;
            end
            addr = (b2 - CH_0) * DIGIT_BASE + (b3 - CH_0);
            if (addr >= STORE_WORDS ||
                ((code == I_GD || code == I_PD) && addr + CARD_WORDS > STORE_WORDS)) begin
                mode = STOPPED;
                queue_result(K_ERR, '0);
                return;
            end
            case (code)
                I_LR: reg_r = store[addr];
                I_SR: store[addr] = reg_r;
                I_CR: flag = (reg_r == store[addr]);
                I_BT:
                begin
                    if (flag) ctr = addr;
                end
                I_GD:
                begin
                    mode = AWAITING;
                    card_base = addr;
                    card_count = 0;
                end
                default:
                begin
                    for (i = 0; i < CARD_WORDS; i++) begin
                        for (s = 3; s >= 0; s--) begin
                            if (store[addr + i][8*s +: 8] != 8'h00)
                                queue_result(K_BYTE, store[addr + i][8*s +: 8]);
                        end
                    end
                end
            endcase
            if (code == I_GD) queue_result(K_CARD, '0);
            else if (code == I_PD) queue_result(K_EOL, '0);
            else queue_result(K_DONE, '0);
        endfunction

        function void note_command(cmd_t c);
            rsp_t r;
            step_kind.delete();
            step_byte.delete();
            ops_seen[int'(c.op)]++;
            case (c.op)
                OP_LOAD:
                begin
                    if (c.load_addr < STORE_WORDS) store[c.load_addr] = c.word_in;
                    queue_result(K_DONE, '0);
                end
                OP_EXEC:
                begin
                    if (mode == STOPPED) queue_result(K_HALT, '0);
                    else if (mode == AWAITING) queue_result(K_CARD, '0);
                    else run_instruction();
                end
                OP_CARD:
                begin
                    if (mode == AWAITING) begin
                        if (card_base + card_count < STORE_WORDS)
                            store[card_base + card_count] = c.word_in;
                        card_count++;
                        if (card_count >= CARD_WORDS) begin
                            card_count = 0;
                            mode = RUNNING;
                            queue_result(K_DONE, '0);
                        end else begin
                            queue_result(K_CARD, '0);
                        end
                    end else begin
                        queue_result(K_DONE, '0);
                    end
                end
                default:
                begin
                    clear_machine();
                    queue_result(K_DONE, '0);
                end
            endcase
            foreach (step_kind[i]) begin
                r.kind = step_kind[i];
                r.out_byte = step_byte[i];
                r.last = (i == step_kind.size() - 1);
                r.next_counter = CTR_W'(ctr);
                r.compare_flag = flag;
                pending_results.push_back(r);
            end
        endfunction

        function void check_result(rsp_t got, longint unsigned stamp);
            rsp_t want;
            checked++;
            if (got.kind <= K_ERR) kinds_seen[int'(got.kind)]++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d ns: result with nothing expected: kind=%0d byte=%h last=%b",
                             stamp, got.kind, got.out_byte, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.last !== want.last || got.next_counter !== want.next_counter ||
                got.compare_flag !== want.compare_flag) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d ns: mismatch: expected kind=%0d byte=%h last=%b ctr=%0d flag=%b",
                             stamp, want.kind, want.out_byte, want.last, want.next_counter,
                             want.compare_flag, "; actual kind=%0d byte=%h last=%b ctr=%0d flag=%b",
                             got.kind, got.out_byte, got.last, got.next_counter,
                             got.compare_flag);
            end
        endfunction

        function bit is_ignored(cmd_t c);
            return (c.op == OP_LOAD && c.load_addr >= STORE_WORDS) ||
                   (c.op == OP_CARD && mode != AWAITING);
        endfunction

        function bit awaiting();
            return mode == AWAITING;
        endfunction

        function bit stopped();
            return mode == STOPPED;
        endfunction

        function int unsigned pc_value();
            return ctr;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

module card_machine_instruction_executor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cme_pkg::*;
    import cme_tb_pkg::*;

    // Number of counted random commands, split about evenly over four traffic mixes.
    localparam int RANDOM_ITEMS = 210;
    // Cycles allowed after the last expected result; longer than a full print.
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Percent chance, per cycle, that the command side sits idle and that the
    // response side stalls. Each is set anew for every traffic mix.
    int sender_pct;
    int stall_pct;
    // Commands that do real work; ignored loads and stray card words do not count.
    int stim_count;

    card_machine_checker sb = new();

    card_machine_instruction_executor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. The slowest legal run (every command printing a full block
    // with long response stalls) stays well inside this bound.
    initial
    begin
        #20ms;
        $display("Watchdog expired with %0d results still owed.", sb.outstanding());
        $display("FAIL");
        $finish;
    end

    // Both channels are sampled at the rising edge. A command transfer is
    // noted before any response of the same edge is checked; a response can
    // never belong to a command that transfers at the same edge anyway.
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall) sb.note_command(cmd);
        if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp, $time);
    end

    // The response side decides a fresh stall every cycle at the falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic cmd_t make_cmd(op_t op, logic [LOAD_ADDR_W-1:0] addr,
                                      logic [WORD_W-1:0] word);
        cmd_t c;
        c.op = op;
        c.load_addr = addr;
        c.word_in = word;
        return c;
    endfunction

    // Fully random command: any opcode, any 7-bit address, any word.
    function automatic cmd_t noise_cmd();
        return make_cmd(op_t'($urandom_range(3)), LOAD_ADDR_W'($urandom), $urandom);
    endfunction

    // Two ASCII decimal digits for an operand address.
    function automatic logic [15:0] digits(int a);
        return {8'(CH_0 + a / DIGIT_BASE), 8'(CH_0 + a % DIGIT_BASE)};
    endfunction

    // Mostly well-formed instructions, so that programs get past the first few
    // steps; the rest halt, do nothing, or carry a bad operand.
    function automatic logic [WORD_W-1:0] random_instruction();
        int pick;
        int addr;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        pick = $urandom_range(99);
        addr = $urandom_range(STORE_WORDS - 1);
        if (pick < 16) {hi, lo} = {CH_L, CH_R};
        else if (pick < 28) {hi, lo} = {CH_S, CH_R};
        else if (pick < 42) {hi, lo} = {CH_C, CH_R};
        else if (pick < 54) {hi, lo} = {CH_B, CH_T};
        else if (pick < 76) begin
            // Card read or print, with a block that fits in the store.
            {hi, lo} = (pick < 64) ? {CH_G, CH_D} : {CH_P, CH_D};
            addr = $urandom_range(STORE_WORDS - CARD_WORDS);
        end
        else if (pick < 81) return {CH_H, 24'($urandom)};
        else if (pick < 85) return $urandom;
        else if (pick < 88) return {CH_P, CH_R, digits(addr)};
        else if (pick < 94) begin
            // Block that would run past the end of the store.
            hi = ($urandom_range(1) == 0) ? CH_G : CH_P;
            return {hi, CH_D,
                    digits($urandom_range(STORE_WORDS - CARD_WORDS + 1, STORE_WORDS - 1))};
        end
        else return {CH_B, CH_T, 8'($urandom), 8'($urandom)};
        return {hi, lo, digits(addr)};
    endfunction

    // Data and card contents: zero words, raw random words, text with some
    // null bytes, or instructions (so that a read card can later run).
    function automatic logic [WORD_W-1:0] data_word();
        logic [WORD_W-1:0] w;
        int i;
        case ($urandom_range(4))
            0: w = '0;
            1: w = $urandom;
            2: w = random_instruction();
            default:
            begin
                for (i = 0; i < 4; i++)
                    w[8*i +: 8] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(32, 126));
            end
        endcase
        return w;
    endfunction

    function automatic int idle_cycles(int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Drives one command and returns at the falling edge after its transfer.
    // Every call starts at a falling edge, so valid is assigned at most once
    // per time step. During an idle gap the payload is scrambled.
    task automatic send_command(cmd_t c);
        int gap;
        if (!sb.is_ignored(c)) stim_count++;
        gap = idle_cycles(sender_pct);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            cmd <= noise_cmd();
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
    endtask

    // Hands in card words until the machine stops waiting. Now and then a
    // stray command cuts in, or the card is left short for a later job.
    task automatic feed_card();
        while (sb.awaiting()) begin
            if ($urandom_range(19) == 0)
                send_command(noise_cmd());
            else if ($urandom_range(39) == 0)
                break;
            else
                send_command(make_cmd(OP_CARD, LOAD_ADDR_W'($urandom), data_word()));
        end
    endtask

    // One job: maybe a fresh start, a short program written at the current
    // counter, a few data words, then a run of steps with cards fed on demand.
    task automatic run_job();
        int n;
        int base;
        int steps;
        int i;
        if (sb.stopped() ? ($urandom_range(4) != 0) : ($urandom_range(9) == 0))
            send_command(make_cmd(OP_CLEAR, LOAD_ADDR_W'($urandom), $urandom));
        n = $urandom_range(3, 10);
        base = sb.pc_value();
        for (i = 0; i < n; i++)
            send_command(make_cmd(OP_LOAD, LOAD_ADDR_W'((base + i) % STORE_WORDS),
                                  random_instruction()));
        repeat ($urandom_range(4))
            send_command(make_cmd(OP_LOAD, LOAD_ADDR_W'($urandom_range(STORE_WORDS - 1)),
                                  data_word()));
        steps = $urandom_range(n, n + 8);
        for (i = 0; i < steps; i++) begin
            if (sb.awaiting())
                feed_card();
            else if ($urandom_range(11) == 0)
                send_command(noise_cmd());
            else if (sb.stopped() && $urandom_range(1) == 0)
                break;
            else
                send_command(make_cmd(OP_EXEC, LOAD_ADDR_W'($urandom), $urandom));
        end
    endtask

    // Directed opening. The program reads a card into the top ten words,
    // prints them, sets the flag, branches to the last word, wraps the
    // counter and then stops on an operand with a letter in it.
    task automatic run_directed();
        logic [WORD_W-1:0] card [CARD_WORDS];
        int i;
        card[0] = 32'h0000_0000;
        card[1] = 32'hFFFF_FFFF;
        card[2] = {"A", 8'h00, "B", 8'h00};
        card[3] = 32'h8000_0001;
        card[4] = 32'h0000_007F;
        card[5] = 32'h7F00_0000;
        card[6] = 32'h2020_2020;
        card[7] = 32'h0102_0304;
        card[8] = {CH_H, 24'h00_0000};
        card[9] = {CH_S, CH_R, digits(0)};

        send_command(make_cmd(OP_CLEAR, '0, '0));
        // A card word while running and a load past the store are both no-ops.
        send_command(make_cmd(OP_CARD, '0, 32'hDEAD_BEEF));
        send_command(make_cmd(OP_LOAD, '1, '1));
        // Word 0 is still zero, which is not an opcode.
        send_command(make_cmd(OP_EXEC, '0, '0));
        send_command(make_cmd(OP_LOAD, 7'd1, {CH_G, CH_D, digits(STORE_WORDS - CARD_WORDS)}));
        send_command(make_cmd(OP_EXEC, '1, '1));
        // A step while the card is outstanding only reports the wait.
        send_command(make_cmd(OP_EXEC, '0, '0));
        for (i = 0; i < CARD_WORDS; i++)
            send_command(make_cmd(OP_CARD, LOAD_ADDR_W'(i), card[i]));
        send_command(make_cmd(OP_LOAD, 7'd2, {CH_P, CH_D, digits(STORE_WORDS - CARD_WORDS)}));
        send_command(make_cmd(OP_EXEC, '0, '0));
        send_command(make_cmd(OP_LOAD, 7'd3, {CH_C, CH_R, digits(STORE_WORDS - CARD_WORDS)}));
        send_command(make_cmd(OP_EXEC, '0, '0));
        send_command(make_cmd(OP_LOAD, 7'd4, {CH_B, CH_T, digits(STORE_WORDS - 1)}));
        send_command(make_cmd(OP_EXEC, '0, '0));
        // The last word holds a store to word 0; the counter wraps after it.
        send_command(make_cmd(OP_EXEC, '0, '0));
        send_command(make_cmd(OP_LOAD, 7'd0, {CH_L, CH_R, CH_9, "A"}));
        send_command(make_cmd(OP_EXEC, '0, '0));
        send_command(make_cmd(OP_EXEC, '0, '0));
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        sender_pct = 0;
        stall_pct = 0;
        stim_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // Four traffic mixes: none, a mostly idle command side, a mostly
        // stalled response side, and light pressure on both at once.
        stim_count = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    sender_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_pct = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_pct = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    sender_pct = 25;
                    stall_pct = 25;
                end
            endcase
            while (stim_count < (phase + 1) * RANDOM_ITEMS / 4) run_job();
        end
        cmd_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d loads, %0d steps, %0d card words and %0d job clears; %0d results checked.",
                 sb.ops_seen[0], sb.ops_seen[1], sb.ops_seen[2], sb.ops_seen[3], sb.checked);
        $display("Result kinds: done %0d, card %0d, byte %0d, end of line %0d, halt %0d, error %0d.",
                 sb.kinds_seen[0], sb.kinds_seen[1], sb.kinds_seen[2], sb.kinds_seen[3],
                 sb.kinds_seen[4], sb.kinds_seen[5]);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
